[rtl/core/bql_pkg.sv]
package bql_pkg;

    // fixed formats of the sample and coefficient fields
    localparam int CHANNELS        = 8;
    localparam int SAMPLE_BITS     = 24;
    localparam int COEFF_FRAC_BITS = 22;
    localparam int CH_BITS         = 3;
    localparam int GAIN_BITS       = 23;
    localparam int COEFF_BITS      = 24;
    localparam int CFG_BITS        = 24;
    localparam int CFG_IDX_BITS    = 2;

    // state memory addressing
    localparam int CH_ADDR_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

    // datapath widths: x + 2*x1 + x2, then the three products and their sum
    localparam int SUM_W = SAMPLE_BITS + 2;
    localparam int PB_W  = SUM_W + GAIN_BITS + 1;
    localparam int PA_W  = SAMPLE_BITS + COEFF_BITS;
    localparam int ACC_W = ((PB_W > PA_W) ? PB_W : PA_W) + 2;

    // rounding and saturation constants in accumulator format
    localparam logic signed [ACC_W-1:0] ROUND_HALF = ACC_W'(1) << (COEFF_FRAC_BITS - 1);
    localparam logic signed [ACC_W-1:0] SAT_MAX    =
        (ACC_W'(1) << (SAMPLE_BITS - 1)) - ACC_W'(1);
    localparam logic signed [ACC_W-1:0] SAT_MIN    = -SAT_MAX - ACC_W'(1);

    // result queue
    localparam int FIFO_DEPTH = 8;
    localparam int FIFO_PTR_W = $clog2(FIFO_DEPTH);
    localparam int FIFO_CNT_W = $clog2(FIFO_DEPTH + 1);

    // configuration register indexes
    typedef enum logic [CFG_IDX_BITS-1:0] {
        REG_GAIN_B0     = 2'd0,
        REG_FEEDBACK_A1 = 2'd1,
        REG_FEEDBACK_A2 = 2'd2
    } bql_reg_idx_t;

    // request payloads
    typedef struct packed {
        logic [CH_BITS-1:0]            channel_index;
        logic signed [SAMPLE_BITS-1:0] sample_in;
    } bql_in_t;

    typedef struct packed {
        logic [CH_BITS-1:0]            channel_out;
        logic signed [SAMPLE_BITS-1:0] sample_out;
    } bql_out_t;

    // per-channel delay line word
    typedef struct packed {
        logic signed [SAMPLE_BITS-1:0] x1;
        logic signed [SAMPLE_BITS-1:0] x2;
        logic signed [SAMPLE_BITS-1:0] y1;
        logic signed [SAMPLE_BITS-1:0] y2;
    } bql_state_t;

    // state memory write port
    typedef struct packed {
        logic                 en;
        logic [CH_ADDR_W-1:0] addr;
        bql_state_t           data;
    } bql_wr_t;

    // occupancy of the pipeline stages, for the channel interlock
    typedef struct packed {
        logic               a_vld;
        logic [CH_BITS-1:0] a_ch;
        logic               b_vld;
        logic [CH_BITS-1:0] b_ch;
        logic               c_vld;
        logic [CH_BITS-1:0] c_ch;
    } bql_busy_t;

endpackage

[rtl/core/bql_state_mem.sv]
module bql_state_mem (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           rd_en,
    input  logic [bql_pkg::CH_ADDR_W-1:0]  rd_addr,
    input  bql_pkg::bql_wr_t               wr,
    output bql_pkg::bql_state_t            rd_data
);
    import bql_pkg::*;

    bql_state_t            state_mem_reg [CHANNELS];
    bql_state_t            rd_word_reg;
    logic [CHANNELS-1:0]   written_reg;
    logic                  rd_written_reg;

    // delay line storage, one word per channel
    always_ff @(posedge clk)
    begin
        if (wr.en)
        begin
            state_mem_reg[wr.addr] <= wr.data;
        end
        if (rd_en)
        begin
            rd_word_reg <= state_mem_reg[rd_addr];
        end
    end

    // written flags stand in for clearing the delay lines at reset
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            written_reg    <= '0;
            rd_written_reg <= 1'b0;
        end
        else
        begin
            if (wr.en)
            begin
                written_reg[wr.addr] <= 1'b1;
            end
            if (rd_en)
            begin
                rd_written_reg <= written_reg[rd_addr];
            end
        end
    end

    // never-written channel reads as cleared
    assign rd_data = rd_written_reg ? rd_word_reg : '0;

endmodule

[rtl/core/bql_datapath.sv]
module bql_datapath (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  accept,
    input  bql_pkg::bql_in_t                      in_item,
    input  bql_pkg::bql_state_t                   rd_state,
    input  logic [bql_pkg::GAIN_BITS-1:0]         gain_b0,
    input  logic signed [bql_pkg::COEFF_BITS-1:0] feedback_a1,
    input  logic signed [bql_pkg::COEFF_BITS-1:0] feedback_a2,
    output bql_pkg::bql_wr_t                      wr,
    output bql_pkg::bql_busy_t                    busy,
    output logic                                  push,
    output bql_pkg::bql_out_t                     result
);
    import bql_pkg::*;

    // stage a: request held while the state word is read
    logic                          a_vld_reg;
    logic                          a_ok_reg;
    bql_in_t                       a_item_reg;
    logic                          a_ok_next;

    // stage b: feedforward sum and delayed samples
    logic                          b_vld_reg;
    logic                          b_ok_reg;
    logic [CH_BITS-1:0]            b_ch_reg;
    logic signed [SAMPLE_BITS-1:0] b_x_reg;
    logic signed [SAMPLE_BITS-1:0] b_x1_reg;
    logic signed [SAMPLE_BITS-1:0] b_y1_reg;
    logic signed [SAMPLE_BITS-1:0] b_y2_reg;
    logic signed [SUM_W-1:0]       b_u_reg;
    logic signed [SUM_W-1:0]       b_u_next;

    // stage c: products
    logic                          c_vld_reg;
    logic                          c_ok_reg;
    logic [CH_BITS-1:0]            c_ch_reg;
    logic signed [SAMPLE_BITS-1:0] c_x_reg;
    logic signed [SAMPLE_BITS-1:0] c_x1_reg;
    logic signed [SAMPLE_BITS-1:0] c_y1_reg;
    logic signed [PB_W-1:0]        c_pb_reg;
    logic signed [PA_W-1:0]        c_pa1_reg;
    logic signed [PA_W-1:0]        c_pa2_reg;
    logic signed [PB_W-1:0]        c_pb_next;
    logic signed [PA_W-1:0]        c_pa1_next;
    logic signed [PA_W-1:0]        c_pa2_next;

    // stage d: accumulate, round, saturate
    logic signed [GAIN_BITS:0]     gain_s;
    logic signed [ACC_W-1:0]       acc;
    logic signed [ACC_W-1:0]       acc_shift;
    logic signed [SAMPLE_BITS-1:0] y_sat;

    // valid flags of the three stages
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_vld_reg <= 1'b0;
            b_vld_reg <= 1'b0;
            c_vld_reg <= 1'b0;
        end
        else
        begin
            a_vld_reg <= accept;
            b_vld_reg <= a_vld_reg;
            c_vld_reg <= b_vld_reg;
        end
    end

    // channels beyond the last one leave the state alone
    assign a_ok_next = ({{(32-CH_BITS){1'b0}}, in_item.channel_index} < 32'(CHANNELS));

    always_comb
    begin
        b_u_next = SUM_W'(a_item_reg.sample_in)
                 + (SUM_W'(rd_state.x1) <<< 1)
                 + SUM_W'(rd_state.x2);
    end

    assign gain_s     = signed'({1'b0, gain_b0});
    assign c_pb_next  = PB_W'(b_u_reg) * PB_W'(gain_s);
    assign c_pa1_next = PA_W'(b_y1_reg) * PA_W'(feedback_a1);
    assign c_pa2_next = PA_W'(b_y2_reg) * PA_W'(feedback_a2);

    // stage payload registers
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            a_item_reg <= in_item;
            a_ok_reg   <= a_ok_next;
        end
        b_ok_reg  <= a_ok_reg;
        b_ch_reg  <= a_item_reg.channel_index;
        b_x_reg   <= a_item_reg.sample_in;
        b_x1_reg  <= rd_state.x1;
        b_y1_reg  <= rd_state.y1;
        b_y2_reg  <= rd_state.y2;
        b_u_reg   <= b_u_next;
        c_ok_reg  <= b_ok_reg;
        c_ch_reg  <= b_ch_reg;
        c_x_reg   <= b_x_reg;
        c_x1_reg  <= b_x1_reg;
        c_y1_reg  <= b_y1_reg;
        c_pb_reg  <= c_pb_next;
        c_pa1_reg <= c_pa1_next;
        c_pa2_reg <= c_pa2_next;
    end

    // sum with round half up, floor shift and clamp to the sample range
    always_comb
    begin
        acc       = ACC_W'(c_pb_reg) - ACC_W'(c_pa1_reg) - ACC_W'(c_pa2_reg) + ROUND_HALF;
        acc_shift = acc >>> COEFF_FRAC_BITS;
        if (acc_shift > SAT_MAX)
        begin
            y_sat = SAT_MAX[SAMPLE_BITS-1:0];
        end
        else if (acc_shift < SAT_MIN)
        begin
            y_sat = SAT_MIN[SAMPLE_BITS-1:0];
        end
        else
        begin
            y_sat = acc_shift[SAMPLE_BITS-1:0];
        end
    end

    // write back the shifted delay line
    assign wr.en      = c_vld_reg && c_ok_reg;
    assign wr.addr    = c_ch_reg[CH_ADDR_W-1:0];
    assign wr.data.x1 = c_x_reg;
    assign wr.data.x2 = c_x1_reg;
    assign wr.data.y1 = y_sat;
    assign wr.data.y2 = c_y1_reg;

    assign push               = c_vld_reg;
    assign result.channel_out = c_ch_reg;
    assign result.sample_out  = c_ok_reg ? y_sat : '0;

    assign busy.a_vld = a_vld_reg;
    assign busy.a_ch  = a_item_reg.channel_index;
    assign busy.b_vld = b_vld_reg;
    assign busy.b_ch  = b_ch_reg;
    assign busy.c_vld = c_vld_reg;
    assign busy.c_ch  = c_ch_reg;

endmodule

[rtl/core/bql_result_fifo.sv]
module bql_result_fifo (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            push,
    input  bql_pkg::bql_out_t               push_data,
    input  logic                            pop,
    output logic                            not_empty,
    output bql_pkg::bql_out_t               head,
    output logic [bql_pkg::FIFO_CNT_W-1:0]  count
);
    import bql_pkg::*;

    bql_out_t                entry_reg [FIFO_DEPTH];
    logic [FIFO_PTR_W-1:0]   wr_ptr_reg;
    logic [FIFO_PTR_W-1:0]   rd_ptr_reg;
    logic [FIFO_CNT_W-1:0]   count_reg;

    // result storage
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_data;
        end
    end

    // pointers and fill level
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_reg + FIFO_PTR_W'(1);
            end
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + FIFO_PTR_W'(1);
            end
            if (push && !pop)
            begin
                count_reg <= count_reg + FIFO_CNT_W'(1);
            end
            else if (pop && !push)
            begin
                count_reg <= count_reg - FIFO_CNT_W'(1);
            end
        end
    end

    assign not_empty = (count_reg != '0);
    assign head      = entry_reg[rd_ptr_reg];
    assign count     = count_reg;

endmodule

[rtl/core/multichannel_biquad_lowpass_core.sv]
// Eight-channel second-order lowpass, direct form 1, Q1.23 samples and Q2.22
// coefficients (b1 = 2*b0, b2 = b0). Each channel's two past inputs and two
// past outputs sit in one word of a small synchronous state memory; a request
// is read from it, goes through a sum stage, a product stage and a
// round/saturate stage, and is written back. Requests on different channels
// are taken one per clock while the queue has a slot for each. A request on a
// channel that is still in those three stages waits until its write-back is
// done. Results pass through an eight-entry queue, and requests keep being
// taken while results wait, until the queued results and the requests in
// flight together reach eight. After reset every channel reads as cleared at
// once. Coefficients must be written through the cfg port only while no
// request is in flight; the block itself does not enforce it.
module multichannel_biquad_lowpass_core (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   in_valid,
    output logic                                   in_ready,
    input  bql_pkg::bql_in_t                       in_data,
    output logic                                   out_valid,
    input  logic                                   out_ready,
    output bql_pkg::bql_out_t                      out_data,
    input  logic                                   cfg_we,
    input  logic [bql_pkg::CFG_IDX_BITS-1:0]       cfg_index,
    input  logic [bql_pkg::CFG_BITS-1:0]           cfg_data
);
    import bql_pkg::*;

    logic [GAIN_BITS-1:0]          gain_b0_reg;
    logic signed [COEFF_BITS-1:0]  feedback_a1_reg;
    logic signed [COEFF_BITS-1:0]  feedback_a2_reg;

    logic                          accept;
    logic                          hazard;
    logic [FIFO_CNT_W-1:0]         fifo_count;
    logic [FIFO_CNT_W-1:0]         credit_used;
    bql_state_t                    rd_state;
    bql_wr_t                       wr;
    bql_busy_t                     busy;
    logic                          push;
    bql_out_t                      result;

    // coefficient registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            gain_b0_reg     <= '0;
            feedback_a1_reg <= '0;
            feedback_a2_reg <= '0;
        end
        else if (cfg_we)
        begin
            case (bql_reg_idx_t'(cfg_index))
                REG_GAIN_B0:     gain_b0_reg     <= cfg_data[GAIN_BITS-1:0];
                REG_FEEDBACK_A1: feedback_a1_reg <= signed'(cfg_data[COEFF_BITS-1:0]);
                REG_FEEDBACK_A2: feedback_a2_reg <= signed'(cfg_data[COEFF_BITS-1:0]);
                default:         ;
            endcase
        end
    end

    // channel interlock against requests not yet written back
    assign hazard = (busy.a_vld && (busy.a_ch == in_data.channel_index))
                 || (busy.b_vld && (busy.b_ch == in_data.channel_index))
                 || (busy.c_vld && (busy.c_ch == in_data.channel_index));

    // every request in flight has a queue slot reserved
    assign credit_used = fifo_count
                       + FIFO_CNT_W'(busy.a_vld)
                       + FIFO_CNT_W'(busy.b_vld)
                       + FIFO_CNT_W'(busy.c_vld);

    assign in_ready = !hazard && (credit_used < FIFO_CNT_W'(FIFO_DEPTH));
    assign accept   = in_valid && in_ready;

    bql_state_mem u_state_mem (
        .clk     (clk),
        .rst_n   (rst_n),
        .rd_en   (accept),
        .rd_addr (in_data.channel_index[CH_ADDR_W-1:0]),
        .wr      (wr),
        .rd_data (rd_state)
    );

    bql_datapath u_datapath (
        .clk         (clk),
        .rst_n       (rst_n),
        .accept      (accept),
        .in_item     (in_data),
        .rd_state    (rd_state),
        .gain_b0     (gain_b0_reg),
        .feedback_a1 (feedback_a1_reg),
        .feedback_a2 (feedback_a2_reg),
        .wr          (wr),
        .busy        (busy),
        .push        (push),
        .result      (result)
    );

    bql_result_fifo u_result_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (result),
        .pop       (out_valid && out_ready),
        .not_empty (out_valid),
        .head      (out_data),
        .count     (fifo_count)
    );

endmodule

[rtl/core/bql_checker.sv]
module bql_checker (
    input logic              clk,
    input logic              rst_n,
    input logic              in_valid,
    input logic              in_ready,
    input bql_pkg::bql_in_t  in_data,
    input logic              out_valid,
    input logic              out_ready,
    input bql_pkg::bql_out_t out_data
);
    import bql_pkg::*;

    logic                  in_take;
    logic                  out_take;
    logic [FIFO_CNT_W:0]   pend_reg;

    assign in_take  = in_valid && in_ready && rst_n;
    assign out_take = out_valid && out_ready;

    // requests taken but not yet delivered
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pend_reg <= '0;
        end
        else if (in_take && !out_take)
        begin
            pend_reg <= pend_reg + (FIFO_CNT_W+1)'(1);
        end
        else if (out_take && !in_take)
        begin
            pend_reg <= pend_reg - (FIFO_CNT_W+1)'(1);
        end
    end

    // a waiting result holds still
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_data))
        else $error("result changed while waiting");

    // no result without a request behind it
    a_no_orphan: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> pend_reg != '0)
        else $error("result without a request");

    // never more in flight than the queue can hold
    a_capacity: assert property (@(posedge clk) disable iff (!rst_n)
        pend_reg <= (FIFO_CNT_W+1)'(FIFO_DEPTH))
        else $error("requests in flight beyond queue depth");

    // a result out of an empty block comes after its request passed stages a, b, c and the queue write
    a_latency: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(in_take, 4))
        else $error("result latency wrong");

    // same channel not taken again before its write-back
    a_interlock: assert property (@(posedge clk) disable iff (!rst_n)
        in_take |->
            !($past(in_take, 1) && (in_data.channel_index == $past(in_data.channel_index, 1)))
         && !($past(in_take, 2) && (in_data.channel_index == $past(in_data.channel_index, 2)))
         && !($past(in_take, 3) && (in_data.channel_index == $past(in_data.channel_index, 3))))
        else $error("channel taken again before write-back");

endmodule

bind multichannel_biquad_lowpass_core bql_checker u_bql_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
);

[tb/sv/biquad_result_checker.sv]
module biquad_result_checker
    import bql_pkg::*;
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    in_valid,
    input  logic                    in_ready,
    input  bql_in_t                 in_data,
    input  logic                    out_valid,
    input  logic                    out_ready,
    input  bql_out_t                out_data,
    input  logic                    cfg_we,
    input  logic [CFG_IDX_BITS-1:0] cfg_index,
    input  logic [CFG_BITS-1:0]     cfg_data,
    output int                      fail_count,
    output int                      outstanding
);

    timeunit 1ns;
    timeprecision 1ps;

    localparam longint SAMPLE_MAX = (longint'(1) << (SAMPLE_BITS - 1)) - 1;
    localparam longint SAMPLE_MIN = -SAMPLE_MAX - 1;
    localparam longint HALF_LSB   = longint'(1) << (COEFF_FRAC_BITS - 1);

    // coefficient copies, b0 held unsigned, a1 and a2 sign extended
    longint gain_b0;
    longint coef_a1;
    longint coef_a2;

    // per-channel delay lines
    longint x1_line [CHANNELS];
    longint x2_line [CHANNELS];
    longint y1_line [CHANNELS];
    longint y2_line [CHANNELS];

    // filtered samples still to come out, oldest first
    bql_out_t filtered_queue [$];

    // one filter step on a channel: result and delay line shift
    function automatic bql_out_t biquad_step(bql_in_t req);
        longint   x;
        longint   acc;
        longint   y;
        int       ch;
        bql_out_t res;
        ch = int'(req.channel_index);
        res.channel_out = req.channel_index;
        res.sample_out  = '0;
        if (ch < CHANNELS)
        begin
            x   = longint'($signed(req.sample_in));
            acc = gain_b0 * (x + 2 * x1_line[ch] + x2_line[ch])
                - coef_a1 * y1_line[ch] - coef_a2 * y2_line[ch];
            // round half up, then clamp to the sample range
            y = (acc + HALF_LSB) >>> COEFF_FRAC_BITS;
            if (y > SAMPLE_MAX)
                y = SAMPLE_MAX;
            else if (y < SAMPLE_MIN)
                y = SAMPLE_MIN;
            x2_line[ch] = x1_line[ch];
            x1_line[ch] = x;
            y2_line[ch] = y1_line[ch];
            y1_line[ch] = y;
            res.sample_out = y[SAMPLE_BITS-1:0];
        end
        return res;
    endfunction

    // follow config writes, requests and results at each edge
    always @(posedge clk or negedge rst_n)
    begin : track
        bql_out_t want;
        int       errs;
        int       c;
        if (!rst_n)
        begin
            gain_b0 = 0;
            coef_a1 = 0;
            coef_a2 = 0;
            for (c = 0; c < CHANNELS; c++)
            begin
                x1_line[c] = 0;
                x2_line[c] = 0;
                y1_line[c] = 0;
                y2_line[c] = 0;
            end
            filtered_queue.delete();
            fail_count  <= 0;
            outstanding <= 0;
        end
        else
        begin
            errs = 0;
            if (cfg_we)
            begin
                case (cfg_index)
                    REG_GAIN_B0:     gain_b0 = longint'(cfg_data[GAIN_BITS-1:0]);
                    REG_FEEDBACK_A1: coef_a1 = longint'($signed(cfg_data[COEFF_BITS-1:0]));
                    REG_FEEDBACK_A2: coef_a2 = longint'($signed(cfg_data[COEFF_BITS-1:0]));
                    default: ;
                endcase
            end
            // results are matched before new requests are queued
            if (out_valid && out_ready)
            begin
                if (filtered_queue.size() == 0)
                begin
                    $display("%0t: unexpected result: channel %0d sample %0d", $time,
                             out_data.channel_out, $signed(out_data.sample_out));
                    errs++;
                end
                else
                begin
                    want = filtered_queue.pop_front();
                    if (out_data.channel_out !== want.channel_out)
                    begin
                        $display("%0t: channel_out mismatch: expected %0d, got %0d", $time,
                                 want.channel_out, out_data.channel_out);
                        errs++;
                    end
                    if (out_data.sample_out !== want.sample_out)
                    begin
                        $display("%0t: sample_out mismatch on channel %0d: expected %0d, got %0d",
                                 $time, want.channel_out, $signed(want.sample_out),
                                 $signed(out_data.sample_out));
                        errs++;
                    end
                end
            end
            if (in_valid && in_ready)
                filtered_queue.push_back(biquad_step(in_data));
            fail_count  <= fail_count + errs;
            outstanding <= filtered_queue.size();
        end
    end

endmodule

[tb/sv/multichannel_biquad_lowpass_core_tb.sv]
module multichannel_biquad_lowpass_core_tb;

    timeunit 1ns;
    timeprecision 1ps;

    import bql_pkg::*;

    localparam logic signed [SAMPLE_BITS-1:0] FULL_POS = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
    localparam logic signed [SAMPLE_BITS-1:0] FULL_NEG = {1'b1, {(SAMPLE_BITS-1){1'b0}}};
    localparam logic [GAIN_BITS-1:0]          B0_MAX   = '1;
    localparam logic [GAIN_BITS-1:0]          B0_UNITY = GAIN_BITS'(1) << COEFF_FRAC_BITS;
    localparam logic signed [COEFF_BITS-1:0]  A_MAX    = {1'b0, {(COEFF_BITS-1){1'b1}}};
    localparam logic signed [COEFF_BITS-1:0]  A_MIN    = {1'b1, {(COEFF_BITS-1){1'b0}}};

    logic                    clk;
    logic                    rst_n;
    logic                    in_valid;
    logic                    in_ready;
    bql_in_t                 in_data;
    logic                    out_valid;
    logic                    out_ready;
    bql_out_t                out_data;
    logic                    cfg_we;
    logic [CFG_IDX_BITS-1:0] cfg_index;
    logic [CFG_BITS-1:0]     cfg_data;

    int fail_count;
    int outstanding;
    int stuck_phases;
    int requests_sent;
    int results_taken;
    bit tx_calm;
    bit rx_calm;
    logic [CH_BITS-1:0] last_channel;

    multichannel_biquad_lowpass_core u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    biquad_result_checker u_checker (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .in_data     (in_data),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .out_data    (out_data),
        .cfg_we      (cfg_we),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .fail_count  (fail_count),
        .outstanding (outstanding)
    );

    // 10 ns clock
    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    // overall time limit
    initial
    begin
        #5_000_000;
        $display("TEST FAILED");
        $finish;
    end

    // result side: random stalls, calm stretches and two long hold-offs
    initial
    begin : result_sink
        int hold;
        out_ready <= 1'b0;
        results_taken = 0;
        rx_calm = 1'b0;
        wait (rst_n === 1'b1);
        @(posedge clk);
        forever
        begin
            if (results_taken == 300 || results_taken == 1100)
                hold = 150;
            else
                hold = rx_calm ? 0 : $urandom_range(0, 14);
            if (hold != 0)
            begin
                out_ready <= 1'b0;
                repeat (hold) @(posedge clk);
            end
            out_ready <= 1'b1;
            do @(posedge clk); while (out_valid !== 1'b1);
            results_taken++;
            if (results_taken % 40 == 0)
                rx_calm = ($urandom_range(0, 3) == 0);
        end
    end

    // offer one request and wait for it to be taken
    task automatic offer_sample(input logic [CH_BITS-1:0] ch,
                                input logic signed [SAMPLE_BITS-1:0] smp);
        int      gap;
        bql_in_t req;
        gap = tx_calm ? 0 : $urandom_range(0, 14);
        if (gap != 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        req.channel_index = ch;
        req.sample_in     = smp;
        in_data  <= req;
        in_valid <= 1'b1;
        do @(posedge clk); while (in_ready !== 1'b1);
        last_channel = ch;
        requests_sent++;
        if (requests_sent % 32 == 0)
            tx_calm = ($urandom_range(0, 3) == 0);
    endtask

    // stop offering and let every result drain
    task automatic settle();
        int waited;
        in_valid <= 1'b0;
        waited = 0;
        repeat (2) @(posedge clk);
        while (outstanding != 0 && waited < 3000)
        begin
            @(posedge clk);
            waited++;
        end
        if (outstanding != 0)
            stuck_phases++;
        repeat (6) @(posedge clk);
    endtask

    // write all three coefficients back to back, block idle
    task automatic load_coefficients(input logic [GAIN_BITS-1:0] b0,
                                     input logic signed [COEFF_BITS-1:0] a1,
                                     input logic signed [COEFF_BITS-1:0] a2);
        cfg_we    <= 1'b1;
        cfg_index <= REG_GAIN_B0;
        cfg_data  <= CFG_BITS'(b0);
        @(posedge clk);
        cfg_index <= REG_FEEDBACK_A1;
        cfg_data  <= CFG_BITS'(a1);
        @(posedge clk);
        cfg_index <= REG_FEEDBACK_A2;
        cfg_data  <= CFG_BITS'(a2);
        @(posedge clk);
        cfg_we <= 1'b0;
    endtask

    // random requests: same-channel runs, extremes, small and full-range samples
    task automatic random_samples(input int count);
        logic [CH_BITS-1:0]            ch;
        logic signed [SAMPLE_BITS-1:0] smp;
        int                            kind;
        repeat (count)
        begin
            if ($urandom_range(0, 3) == 0)
                ch = last_channel;
            else
                ch = CH_BITS'($urandom_range(0, CHANNELS - 1));
            kind = $urandom_range(0, 9);
            case (kind)
                0: smp = FULL_POS;
                1: smp = FULL_NEG;
                2, 3:
                begin
                    smp = SAMPLE_BITS'($urandom_range(0, 64));
                    smp = smp - SAMPLE_BITS'(32);
                end
                default: smp = SAMPLE_BITS'($urandom);
            endcase
            offer_sample(ch, smp);
        end
    endtask

    // stimulus and verdict
    initial
    begin : stimulus
        int c;
        rst_n     <= 1'b0;
        in_valid  <= 1'b0;
        in_data   <= '0;
        cfg_we    <= 1'b0;
        cfg_index <= REG_GAIN_B0;
        cfg_data  <= '0;
        stuck_phases  = 0;
        requests_sent = 0;
        tx_calm       = 1'b0;
        last_channel  = '0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // coefficients still at reset: every result is zero
        offer_sample(3'd0, FULL_POS);
        offer_sample(3'd7, FULL_NEG);
        offer_sample(3'd3, -24'sd1);
        settle();

        // half gain on fresh channels: rounding of exact halves
        load_coefficients(B0_UNITY >> 1, '0, '0);
        offer_sample(3'd5, 24'sd1);
        offer_sample(3'd6, -24'sd1);
        offer_sample(3'd5, 24'sd0);
        offer_sample(3'd6, 24'sd0);
        settle();

        // unity gain, back-to-back on one channel, driven into both clamps
        load_coefficients(B0_UNITY, '0, '0);
        offer_sample(3'd1, FULL_POS);
        offer_sample(3'd1, FULL_POS);
        offer_sample(3'd2, FULL_NEG);
        offer_sample(3'd2, FULL_NEG);
        offer_sample(3'd4, 24'sd0);
        settle();

        // extreme coefficients across every channel
        load_coefficients(B0_MAX, A_MIN, A_MAX);
        for (c = 0; c < CHANNELS; c++)
            offer_sample(CH_BITS'(c), (c % 2 == 0) ? FULL_POS : FULL_NEG);
        settle();

        // random phases over a range of filter settings
        load_coefficients(23'd1228473, 24'sd0, 24'sd719617);
        random_samples(200);
        settle();
        load_coefficients(23'd84229, -24'sd6547393, 24'sd2690033);
        random_samples(200);
        settle();
        load_coefficients(B0_MAX, A_MAX, A_MIN);
        random_samples(200);
        settle();
        load_coefficients('0, A_MIN, A_MAX);
        random_samples(200);
        settle();
        load_coefficients(23'd1, '0, '0);
        random_samples(200);
        settle();
        repeat (3)
        begin
            load_coefficients(GAIN_BITS'($urandom), COEFF_BITS'($urandom),
                              COEFF_BITS'($urandom));
            random_samples(200);
            settle();
        end

        if (fail_count == 0 && stuck_phases == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule

[files.f]
rtl/core/bql_pkg.sv
rtl/core/bql_state_mem.sv
rtl/core/bql_datapath.sv
rtl/core/bql_result_fifo.sv
rtl/core/multichannel_biquad_lowpass_core.sv
rtl/core/bql_checker.sv
tb/sv/biquad_result_checker.sv
tb/sv/multichannel_biquad_lowpass_core_tb.sv
